// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: assertion wrappers shared by the RTL.
// No dependencies. Empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DFP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DFP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DFP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/dfp_pkg.sv =====
// dfp_pkg: types, character codes and tables of the date/time format parser.
// No dependencies; used by every module of the block.
package dfp_pkg;

   localparam int MAX_FORMAT_LEN_DEF = 32;
   localparam int FMT_BYTES          = 32;
   localparam int QUEUE_DEPTH        = 4;

   // pattern and literal characters
   localparam logic [7:0] CH_B_LO = 8'h62;
   localparam logic [7:0] CH_C_LO = 8'h63;
   localparam logic [7:0] CH_D_LO = 8'h64;
   localparam logic [7:0] CH_E_LO = 8'h65;
   localparam logic [7:0] CH_F_LO = 8'h66;
   localparam logic [7:0] CH_K_LO = 8'h6B;
   localparam logic [7:0] CH_H_UP = 8'h48;
   localparam logic [7:0] CH_L_LO = 8'h6C;
   localparam logic [7:0] CH_I_UP = 8'h49;
   localparam logic [7:0] CH_H_LO = 8'h68;
   localparam logic [7:0] CH_I_LO = 8'h69;
   localparam logic [7:0] CH_J_LO = 8'h6A;
   localparam logic [7:0] CH_M_UP = 8'h4D;
   localparam logic [7:0] CH_M_LO = 8'h6D;
   localparam logic [7:0] CH_S_UP = 8'h53;
   localparam logic [7:0] CH_S_LO = 8'h73;
   localparam logic [7:0] CH_P_LO = 8'h70;
   localparam logic [7:0] CH_R_LO = 8'h72;
   localparam logic [7:0] CH_T_UP = 8'h54;
   localparam logic [7:0] CH_Y_UP = 8'h59;
   localparam logic [7:0] CH_Y_LO = 8'h79;
   localparam logic [7:0] CH_A_LO = 8'h61;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_AT   = 8'h40;
   localparam logic [7:0] CH_PCT  = 8'h25;
   localparam logic [7:0] CH_COLON = 8'h3A;

   // mode flag bit positions
   localparam int FLG_DOY = 0;
   localparam int FLG_MER = 1;
   localparam int FLG_H24 = 2;
   localparam int FLG_H12 = 3;

   // configuration register indexes
   localparam logic [2:0] REG_FMT_A = 3'd0;
   localparam logic [2:0] REG_FMT_B = 3'd1;
   localparam logic [2:0] REG_FMT_C = 3'd2;
   localparam logic [2:0] REG_FMT_D = 3'd3;
   localparam logic [2:0] REG_LEN   = 3'd4;

   typedef enum logic [1:0] {
      ST_OK, ST_PARSE_FAIL, ST_BAD_FORMAT, ST_DOY
   } status_type;

   typedef enum logic [1:0] {
      RUN_OK, RUN_FAIL, RUN_DONE
   } run_type;

   typedef enum logic [1:0] {
      MER_NONE, MER_AM, MER_PM
   } mer_type;

   typedef enum logic [1:0] {
      STG_RUN, STG_APPLY, STG_EMIT
   } stage_type;

   typedef enum logic [3:0] {
      PH_FETCH, PH_PCT, PH_START, PH_DIGITS, PH_NDONE, PH_NAME, PH_P2, PH_SKIP,
      PH_TDIG, PH_TDONE, PH_TSEP, PH_TWS, PH_TAP1, PH_TAP2
   } phase_type;

   // one classified string byte
   typedef struct packed {
      logic [7:0] code;
      logic [7:0] lower;
      logic       ws;
      logic       dig;
      logic       alpha;
      logic       punct;
      logic       last;
      logic       empty;
   } item_type;

   typedef struct packed {
      logic done;
      logic bad;
   } chk_type;

   typedef struct packed {
      status_type  status;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [19:0] micro;
   } result_type;

   localparam logic [71:0] MON_TXT [12] = '{
      72'("january"), 72'("february"), 72'("march"), 72'("april"), 72'("may"),
      72'("june"), 72'("july"), 72'("august"), 72'("september"),
      72'("october"), 72'("november"), 72'("december")};
   localparam logic [3:0] MON_LEN [12] = '{
      4'd7, 4'd8, 4'd5, 4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd9, 4'd7, 4'd8, 4'd8};

   function automatic logic [7:0] mon_char(input int m, input logic [3:0] idx);
      logic [71:0] txt;
      logic [3:0]  len;
      logic [7:0]  ch;
      txt = MON_TXT[m];
      len = MON_LEN[m];
      ch  = 8'h00;
      if (idx < len) begin
         ch = txt[(4'(len - idx - 4'd1)) * 8 +: 8];
      end
      return ch;
   endfunction

   function automatic logic known_pat(input logic [7:0] p);
      logic k;
      case (p)
         CH_B_LO, CH_C_LO, CH_D_LO, CH_E_LO, CH_F_LO, CH_K_LO, CH_H_UP, CH_L_LO,
         CH_I_UP, CH_H_LO, CH_I_LO, CH_J_LO, CH_M_UP, CH_M_LO, CH_S_UP, CH_S_LO,
         CH_P_LO, CH_R_LO, CH_T_UP, CH_Y_UP, CH_Y_LO, CH_HASH, CH_DOT, CH_AT,
         CH_PCT: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] pat_limit(input logic [7:0] p);
      logic [2:0] l;
      case (p)
         CH_Y_UP: l = 3'd4;
         CH_J_LO: l = 3'd3;
         CH_F_LO: l = 3'd6;
         default: l = 3'd2;
      endcase
      return l;
   endfunction

   function automatic logic [19:0] pow_ten(input logic [2:0] e);
      logic [19:0] v;
      case (e)
         3'd0: v = 20'd1;
         3'd1: v = 20'd10;
         3'd2: v = 20'd100;
         3'd3: v = 20'd1000;
         3'd4: v = 20'd10000;
         3'd5: v = 20'd100000;
         default: v = 20'd1;
      endcase
      return v;
   endfunction

   function automatic logic [13:0] adjust_year(input logic [19:0] v);
      logic [19:0] y;
      if (v <= 20'd69) y = 20'(v + 20'd2000);
      else if (v <= 20'd99) y = 20'(v + 20'd1900);
      else y = v;
      return y[13:0];
   endfunction

endpackage

// ===== hw/rtl/dfp_front.sv =====
// dfp_front: request intake, byte classification and the short queue to the parser.
// Depends on dfp_pkg.
module dfp_front #(
   parameter int DEPTH = dfp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] char_code
   input  logic              req_tlast,
   input  logic              req_tuser,   // [0] empty_string
   output logic              q_valid,
   output dfp_pkg::item_type q_item,
   input  logic              q_pop
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   dfp_pkg::item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   dfp_pkg::item_type new_item;
   logic push;

   always_comb begin
      new_item.code  = req_tdata;
      new_item.lower = (req_tdata inside {[8'h41:8'h5A]}) ? 8'(req_tdata + 8'd32) : req_tdata;
      new_item.ws    = req_tdata inside {8'h20, [8'h09:8'h0D]};
      new_item.dig   = req_tdata inside {[8'h30:8'h39]};
      new_item.alpha = req_tdata inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      new_item.punct = req_tdata inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60],
                                         [8'h7B:8'h7E]};
      new_item.last  = req_tlast;
      new_item.empty = req_tuser;
   end

   assign req_tready = (count_ff != CW'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      if (q_pop) rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      count_in = CW'(count_ff + CW'(push) - CW'(q_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= new_item;
   end

endmodule

// ===== hw/rtl/dfp_fmt_chk.sv =====
// dfp_fmt_chk: walks the stored format byte by byte after each register write
// and flags unknown percent patterns. Depends on dfp_pkg.
module dfp_fmt_chk (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  restart,
   input  logic [dfp_pkg::FMT_BYTES-1:0][7:0]    fmt_bytes,
   input  logic [5:0]                            eff_len,
   output dfp_pkg::chk_type                      chk
);
   logic [5:0] idx_ff, idx_in;
   logic       pend_ff, pend_in, scan_ff, scan_in, bad_ff, bad_in;
   logic [7:0] cur;

   assign cur = fmt_bytes[idx_ff[4:0]];

   always_comb begin
      idx_in  = idx_ff;
      pend_in = pend_ff;
      scan_in = scan_ff;
      bad_in  = bad_ff;
      if (restart) begin
         idx_in  = '0;
         pend_in = 1'b0;
         scan_in = 1'b1;
         bad_in  = 1'b0;
      end else if (scan_ff) begin
         if (idx_ff >= eff_len) begin
            scan_in = 1'b0;
         end else if (pend_ff) begin
            if (!dfp_pkg::known_pat(cur)) begin
               bad_in  = 1'b1;
               scan_in = 1'b0;
            end
            idx_in  = 6'(idx_ff + 6'd1);
            pend_in = 1'b0;
         end else if (cur == dfp_pkg::CH_PCT) begin
            // a lone percent at the end is ignored
            if (7'(idx_ff) + 7'd1 >= 7'(eff_len)) scan_in = 1'b0;
            else begin
               idx_in  = 6'(idx_ff + 6'd1);
               pend_in = 1'b1;
            end
         end else begin
            idx_in = 6'(idx_ff + 6'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pend_ff <= 1'b0;
         scan_ff <= 1'b1;
         bad_ff  <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         pend_ff <= pend_in;
         scan_ff <= scan_in;
         bad_ff  <= bad_in;
      end
   end

   assign chk.done = !scan_ff;
   assign chk.bad  = bad_ff;

endmodule

// ===== hw/rtl/dfp_back.sv =====
// dfp_back: format-driven parse engine, one step a cycle on the head of the queue while bytes
// are queued and no result waits to be emitted, plus end-of-string checks. Depends on dfp_pkg.
module dfp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  dfp_pkg::item_type                     q_item,
   output logic                                  q_pop,
   input  logic [dfp_pkg::FMT_BYTES-1:0][7:0]    fmt_bytes,
   input  logic [5:0]                            eff_len,
   input  dfp_pkg::chk_type                      chk,
   input  logic                                  out_free,
   output logic                                  res_valid,
   output dfp_pkg::result_type                   res
);
   dfp_pkg::stage_type stage_ff, stage_in;
   dfp_pkg::phase_type phase_ff, phase_in;
   dfp_pkg::run_type   failed_ff, failed_in;
   dfp_pkg::mer_type   mer_ff, mer_in, ap_ff, ap_in;
   logic [5:0]  cursor_ff, cursor_in;
   logic [19:0] accum_ff, accum_in;
   logic [2:0]  dcount_ff, dcount_in;
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in, hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in, second_ff, second_in;
   logic [19:0] micro_ff, micro_in;
   logic [3:0]  flags_ff, flags_in;
   logic [7:0]  pat_ff, pat_in;
   logic        lit_ff, lit_in;
   logic [11:0] nmask_ff, nmask_in;
   logic [3:0]  nidx_ff, nidx_in;
   logic [1:0]  tfield_ff, tfield_in;

   logic [7:0]  fbyte;
   logic [19:0] accum_dig, micro_scaled;
   logic [39:0] micro_prod;
   logic [11:0] keep;
   logic [3:0]  hit, mlen;
   logic        hit_found, consume, do_num, do_tf, in_class, twelve;
   dfp_pkg::status_type st;
   logic [4:0]  hour_adj;

   assign fbyte        = fmt_bytes[cursor_ff[4:0]];
   assign accum_dig    = 20'(accum_ff * 20'd10 + {16'd0, q_item.code[3:0]});
   assign micro_prod   = accum_ff * dfp_pkg::pow_ten(3'(3'd6 - dcount_ff));
   assign micro_scaled = micro_prod[19:0];
   assign twelve       = (pat_ff == dfp_pkg::CH_R_LO);

   // month name matching, all twelve names side by side
   always_comb begin
      keep      = '0;
      hit       = '0;
      hit_found = 1'b0;
      for (int m = 11; m >= 0; m--) begin
         mlen = (pat_ff == dfp_pkg::CH_B_LO) ? 4'd3 : dfp_pkg::MON_LEN[m];
         if (nmask_ff[m] && nidx_ff < mlen && q_item.lower == dfp_pkg::mon_char(m, nidx_ff))
         begin
            keep[m] = 1'b1;
            if (4'(nidx_ff + 4'd1) == mlen) begin
               hit       = 4'(m);
               hit_found = 1'b1;
            end
         end
      end
   end

   always_comb begin
      case (pat_ff)
         dfp_pkg::CH_HASH: in_class = q_item.dig;
         dfp_pkg::CH_DOT:  in_class = q_item.punct;
         default:          in_class = q_item.alpha;
      endcase
   end

   // end-of-string status and hour fixing
   always_comb begin
      hour_adj = hour_ff;
      if (chk.bad) st = dfp_pkg::ST_BAD_FORMAT;
      else if (failed_ff == dfp_pkg::RUN_FAIL) st = dfp_pkg::ST_PARSE_FAIL;
      else if (flags_ff[dfp_pkg::FLG_DOY]) st = dfp_pkg::ST_DOY;
      else if (flags_ff[dfp_pkg::FLG_MER]) begin
         if (flags_ff[dfp_pkg::FLG_H24] || hour_ff == 5'd0 || hour_ff > 5'd12) begin
            st = dfp_pkg::ST_PARSE_FAIL;
         end else begin
            st = dfp_pkg::ST_OK;
            if (hour_ff == 5'd12) hour_adj = (mer_ff == dfp_pkg::MER_AM) ? 5'd0 : 5'd12;
            else if (mer_ff == dfp_pkg::MER_PM) hour_adj = 5'(hour_ff + 5'd12);
         end
      end else begin
         st = dfp_pkg::ST_OK;
         if (flags_ff[dfp_pkg::FLG_H12] && hour_ff == 5'd12) hour_adj = 5'd0;
      end
   end

   always_comb begin
      stage_in  = stage_ff;  phase_in  = phase_ff;  failed_in = failed_ff;
      mer_in    = mer_ff;    ap_in     = ap_ff;     cursor_in = cursor_ff;
      accum_in  = accum_ff;  dcount_in = dcount_ff; year_in   = year_ff;
      month_in  = month_ff;  day_in    = day_ff;    hour_in   = hour_ff;
      minute_in = minute_ff; second_in = second_ff; micro_in  = micro_ff;
      flags_in  = flags_ff;  pat_in    = pat_ff;    lit_in    = lit_ff;
      nmask_in  = nmask_ff;  nidx_in   = nidx_ff;   tfield_in = tfield_ff;
      q_pop     = 1'b0;
      res_valid = 1'b0;
      consume   = 1'b0;
      do_num    = 1'b0;
      do_tf     = 1'b0;
      res.status = st;
      res.year   = (st == dfp_pkg::ST_OK) ? year_ff : '0;
      res.month  = (st == dfp_pkg::ST_OK) ? month_ff : '0;
      res.day    = (st == dfp_pkg::ST_OK) ? day_ff : '0;
      res.hour   = (st == dfp_pkg::ST_OK) ? hour_adj : '0;
      res.minute = (st == dfp_pkg::ST_OK) ? minute_ff : '0;
      res.second = (st == dfp_pkg::ST_OK) ? second_ff : '0;
      res.micro  = (st == dfp_pkg::ST_OK) ? micro_ff : '0;

      case (stage_ff)
         dfp_pkg::STG_RUN: begin
            if (q_valid) begin
               if (q_item.empty) begin
                  q_pop    = 1'b1;
                  stage_in = dfp_pkg::STG_APPLY;
               end else begin
                  if (failed_ff != dfp_pkg::RUN_OK) consume = 1'b1;
                  else begin
                     case (phase_ff)
                        dfp_pkg::PH_FETCH: begin
                           if (cursor_ff >= eff_len) failed_in = dfp_pkg::RUN_DONE;
                           else if (fbyte inside {8'h20, [8'h09:8'h0D]}) begin
                              cursor_in = 6'(cursor_ff + 6'd1);
                           end else if (fbyte == dfp_pkg::CH_PCT) begin
                              if (7'(cursor_ff) + 7'd1 >= 7'(eff_len)) begin
                                 cursor_in = eff_len;
                                 failed_in = dfp_pkg::RUN_DONE;
                              end else begin
                                 cursor_in = 6'(cursor_ff + 6'd1);
                                 phase_in  = dfp_pkg::PH_PCT;
                              end
                           end else begin
                              pat_in    = fbyte;
                              lit_in    = 1'b1;
                              cursor_in = 6'(cursor_ff + 6'd1);
                              phase_in  = dfp_pkg::PH_START;
                           end
                        end
                        dfp_pkg::PH_PCT: begin
                           pat_in    = fbyte;
                           lit_in    = 1'b0;
                           cursor_in = 6'(cursor_ff + 6'd1);
                           phase_in  = dfp_pkg::PH_START;
                        end
                        dfp_pkg::PH_START: begin
                           if (q_item.ws) consume = 1'b1;
                           else if (lit_ff) begin
                              consume = 1'b1;
                              if (q_item.code == pat_ff) phase_in = dfp_pkg::PH_FETCH;
                              else failed_in = dfp_pkg::RUN_FAIL;
                           end else begin
                              accum_in  = '0;
                              dcount_in = '0;
                              case (pat_ff)
                                 dfp_pkg::CH_B_LO, dfp_pkg::CH_M_UP: begin
                                    nmask_in = '1;
                                    nidx_in  = '0;
                                    phase_in = dfp_pkg::PH_NAME;
                                 end
                                 dfp_pkg::CH_P_LO: begin
                                    consume = 1'b1;
                                    if (q_item.lower == dfp_pkg::CH_A_LO) mer_in = dfp_pkg::MER_AM;
                                    else if (q_item.lower == dfp_pkg::CH_P_LO)
                                       mer_in = dfp_pkg::MER_PM;
                                    else failed_in = dfp_pkg::RUN_FAIL;
                                    phase_in = dfp_pkg::PH_P2;
                                 end
                                 dfp_pkg::CH_R_LO, dfp_pkg::CH_T_UP: begin
                                    tfield_in = '0;
                                    phase_in  = dfp_pkg::PH_TDIG;
                                 end
                                 dfp_pkg::CH_HASH, dfp_pkg::CH_DOT, dfp_pkg::CH_AT: begin
                                    phase_in = dfp_pkg::PH_SKIP;
                                 end
                                 dfp_pkg::CH_PCT: begin
                                    consume   = 1'b1;
                                    failed_in = dfp_pkg::RUN_FAIL;
                                 end
                                 default: phase_in = dfp_pkg::PH_DIGITS;
                              endcase
                           end
                        end
                        dfp_pkg::PH_DIGITS: begin
                           if (q_item.dig) begin
                              consume   = 1'b1;
                              accum_in  = accum_dig;
                              dcount_in = 3'(dcount_ff + 3'd1);
                              if (3'(dcount_ff + 3'd1) == dfp_pkg::pat_limit(pat_ff))
                                 phase_in = dfp_pkg::PH_NDONE;
                           end else do_num = 1'b1;
                        end
                        dfp_pkg::PH_NDONE: do_num = 1'b1;
                        dfp_pkg::PH_NAME: begin
                           consume  = 1'b1;
                           nmask_in = keep;
                           nidx_in  = 4'(nidx_ff + 4'd1);
                           if (hit_found) begin
                              month_in = 4'(hit + 4'd1);
                              phase_in = dfp_pkg::PH_FETCH;
                           end else if (keep == '0) failed_in = dfp_pkg::RUN_FAIL;
                        end
                        dfp_pkg::PH_P2: begin
                           consume = 1'b1;
                           if (q_item.lower == dfp_pkg::CH_M_LO) begin
                              flags_in[dfp_pkg::FLG_MER] = 1'b1;
                              phase_in = dfp_pkg::PH_FETCH;
                           end else failed_in = dfp_pkg::RUN_FAIL;
                        end
                        dfp_pkg::PH_SKIP: begin
                           if (in_class) consume = 1'b1;
                           else phase_in = dfp_pkg::PH_FETCH;
                        end
                        dfp_pkg::PH_TDIG: begin
                           if (q_item.dig) begin
                              consume   = 1'b1;
                              accum_in  = accum_dig;
                              dcount_in = 3'(dcount_ff + 3'd1);
                              if (dcount_ff == 3'd1) phase_in = dfp_pkg::PH_TDONE;
                           end else do_tf = 1'b1;
                        end
                        dfp_pkg::PH_TDONE: do_tf = 1'b1;
                        dfp_pkg::PH_TSEP: begin
                           consume = 1'b1;
                           if (!q_item.ws) begin
                              if (q_item.code == dfp_pkg::CH_COLON) begin
                                 tfield_in = 2'(tfield_ff + 2'd1);
                                 phase_in  = dfp_pkg::PH_TWS;
                              end else failed_in = dfp_pkg::RUN_FAIL;
                           end
                        end
                        dfp_pkg::PH_TWS: begin
                           if (q_item.ws) consume = 1'b1;
                           else begin
                              accum_in  = '0;
                              dcount_in = '0;
                              phase_in  = dfp_pkg::PH_TDIG;
                           end
                        end
                        dfp_pkg::PH_TAP1: begin
                           consume = 1'b1;
                           if (!q_item.ws) begin
                              if (q_item.lower == dfp_pkg::CH_A_LO) ap_in = dfp_pkg::MER_AM;
                              else if (q_item.lower == dfp_pkg::CH_P_LO) ap_in = dfp_pkg::MER_PM;
                              else failed_in = dfp_pkg::RUN_FAIL;
                              phase_in = dfp_pkg::PH_TAP2;
                           end
                        end
                        dfp_pkg::PH_TAP2: begin
                           consume = 1'b1;
                           if (q_item.lower == dfp_pkg::CH_M_LO) begin
                              if (ap_ff == dfp_pkg::MER_PM) hour_in = 5'(hour_ff + 5'd12);
                              phase_in = dfp_pkg::PH_FETCH;
                           end else failed_in = dfp_pkg::RUN_FAIL;
                        end
                        default: begin
                           consume   = 1'b1;
                           failed_in = dfp_pkg::RUN_FAIL;
                        end
                     endcase
                  end
                  if (consume) begin
                     q_pop = 1'b1;
                     if (q_item.last) stage_in = dfp_pkg::STG_APPLY;
                  end
               end
            end
         end
         dfp_pkg::STG_APPLY: begin
            // close whatever element the string ended in
            if (failed_ff == dfp_pkg::RUN_OK) begin
               case (phase_ff)
                  dfp_pkg::PH_DIGITS, dfp_pkg::PH_NDONE: do_num = 1'b1;
                  dfp_pkg::PH_TDIG, dfp_pkg::PH_TDONE:   do_tf = 1'b1;
                  dfp_pkg::PH_NAME, dfp_pkg::PH_P2, dfp_pkg::PH_TAP2:
                     failed_in = dfp_pkg::RUN_FAIL;
                  default: ;
               endcase
            end
            stage_in = dfp_pkg::STG_EMIT;
         end
         dfp_pkg::STG_EMIT: begin
            if (chk.done && out_free) begin
               res_valid = 1'b1;
               stage_in  = dfp_pkg::STG_RUN;
               phase_in  = dfp_pkg::PH_FETCH;  failed_in = dfp_pkg::RUN_OK;
               mer_in    = dfp_pkg::MER_NONE;  ap_in     = dfp_pkg::MER_NONE;
               cursor_in = '0; accum_in  = '0; dcount_in = '0; year_in   = '0;
               month_in  = '0; day_in    = '0; hour_in   = '0; minute_in = '0;
               second_in = '0; micro_in  = '0; flags_in  = '0; pat_in    = '0;
               lit_in    = '0; nmask_in  = '0; nidx_in   = '0; tfield_in = '0;
            end
         end
         default: stage_in = dfp_pkg::STG_RUN;
      endcase

      if (do_num) begin
         phase_in = dfp_pkg::PH_FETCH;
         if (dcount_ff == 3'd0) begin
            if (pat_ff == dfp_pkg::CH_F_LO) micro_in = '0;
            else failed_in = dfp_pkg::RUN_FAIL;
         end else begin
            case (pat_ff)
               dfp_pkg::CH_C_LO, dfp_pkg::CH_M_LO: begin
                  if (accum_ff > 20'd12) failed_in = dfp_pkg::RUN_FAIL;
                  else month_in = accum_ff[3:0];
               end
               dfp_pkg::CH_D_LO, dfp_pkg::CH_E_LO: begin
                  if (accum_ff > 20'd31) failed_in = dfp_pkg::RUN_FAIL;
                  else day_in = accum_ff[4:0];
               end
               dfp_pkg::CH_F_LO: micro_in = micro_scaled;
               dfp_pkg::CH_K_LO, dfp_pkg::CH_H_UP: begin
                  if (accum_ff > 20'd23) failed_in = dfp_pkg::RUN_FAIL;
                  else begin
                     hour_in = accum_ff[4:0];
                     flags_in[dfp_pkg::FLG_H24] = 1'b1;
                  end
               end
               dfp_pkg::CH_L_LO, dfp_pkg::CH_I_UP, dfp_pkg::CH_H_LO: begin
                  if (accum_ff == 20'd0 || accum_ff > 20'd12) failed_in = dfp_pkg::RUN_FAIL;
                  else begin
                     hour_in = accum_ff[4:0];
                     flags_in[dfp_pkg::FLG_H12] = 1'b1;
                  end
               end
               dfp_pkg::CH_I_LO: begin
                  if (accum_ff > 20'd59) failed_in = dfp_pkg::RUN_FAIL;
                  else minute_in = accum_ff[5:0];
               end
               dfp_pkg::CH_J_LO: begin
                  if (accum_ff == 20'd0 || accum_ff > 20'd366) failed_in = dfp_pkg::RUN_FAIL;
                  else flags_in[dfp_pkg::FLG_DOY] = 1'b1;
               end
               dfp_pkg::CH_S_UP, dfp_pkg::CH_S_LO: begin
                  if (accum_ff > 20'd59) failed_in = dfp_pkg::RUN_FAIL;
                  else second_in = accum_ff[5:0];
               end
               dfp_pkg::CH_Y_UP: year_in = (dcount_ff <= 3'd2) ?
                                            dfp_pkg::adjust_year(accum_ff) : accum_ff[13:0];
               dfp_pkg::CH_Y_LO: year_in = dfp_pkg::adjust_year(accum_ff);
               default: failed_in = dfp_pkg::RUN_FAIL;
            endcase
         end
      end

      if (do_tf) begin
         if (dcount_ff == 3'd0) failed_in = dfp_pkg::RUN_FAIL;
         else if (tfield_ff == 2'd0) begin
            if (twelve ? (accum_ff == 20'd0 || accum_ff > 20'd12) : (accum_ff > 20'd23))
               failed_in = dfp_pkg::RUN_FAIL;
            else begin
               hour_in  = (twelve && accum_ff == 20'd12) ? 5'd0 : accum_ff[4:0];
               phase_in = dfp_pkg::PH_TSEP;
            end
         end else if (accum_ff > 20'd59) failed_in = dfp_pkg::RUN_FAIL;
         else begin
            if (tfield_ff == 2'd1) begin
               minute_in = accum_ff[5:0];
               phase_in  = dfp_pkg::PH_TSEP;
            end else begin
               second_in = accum_ff[5:0];
               phase_in  = twelve ? dfp_pkg::PH_TAP1 : dfp_pkg::PH_FETCH;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= dfp_pkg::STG_RUN;
         phase_ff  <= dfp_pkg::PH_FETCH;
         failed_ff <= dfp_pkg::RUN_OK;
         mer_ff    <= dfp_pkg::MER_NONE;
         ap_ff     <= dfp_pkg::MER_NONE;
         cursor_ff <= '0; accum_ff  <= '0; dcount_ff <= '0; year_ff   <= '0;
         month_ff  <= '0; day_ff    <= '0; hour_ff   <= '0; minute_ff <= '0;
         second_ff <= '0; micro_ff  <= '0; flags_ff  <= '0; pat_ff    <= '0;
         lit_ff    <= '0; nmask_ff  <= '0; nidx_ff   <= '0; tfield_ff <= '0;
      end else begin
         stage_ff  <= stage_in;
         phase_ff  <= phase_in;
         failed_ff <= failed_in;
         mer_ff    <= mer_in;
         ap_ff     <= ap_in;
         cursor_ff <= cursor_in; accum_ff  <= accum_in;  dcount_ff <= dcount_in;
         year_ff   <= year_in;   month_ff  <= month_in;  day_ff    <= day_in;
         hour_ff   <= hour_in;   minute_ff <= minute_in; second_ff <= second_in;
         micro_ff  <= micro_in;  flags_ff  <= flags_in;  pat_ff    <= pat_in;
         lit_ff    <= lit_in;    nmask_ff  <= nmask_in;  nidx_ff   <= nidx_in;
         tfield_ff <= tfield_in;
      end
   end

endmodule

// ===== hw/rtl/datetime_format_parser.sv =====
// Date/time string parser. After the last byte is popped, the engine closes the open element,
// then emits the result, waiting while the result register is held or the format scan after a
// register write runs. Throughput: one byte per cycle at best, less for each engine step that
// uses no byte: format whitespace, element fetch, percent prefix, start of a pattern other
// than %p or %%, close of a number, time field or skip run, field start after a colon, and the
// close and emit steps per string. Synchronous reset clears format registers, queue and state.
`include "assert_macros.svh"
module datetime_format_parser #(
   parameter int MAX_FORMAT_LEN = dfp_pkg::MAX_FORMAT_LEN_DEF,
   parameter int QUEUE_DEPTH    = dfp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] char_code
   input  logic        req_tlast,    // last_char
   input  logic        req_tuser,    // [0] empty_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // year[13:0] month[17:14] day[22:18] hour[27:23]
                                     // minute[33:28] second[39:34] micro[59:40]
   output logic [1:0]  rsp_tuser,    // [1:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   localparam int LEN_CAP = (MAX_FORMAT_LEN < dfp_pkg::FMT_BYTES) ?
                            MAX_FORMAT_LEN : dfp_pkg::FMT_BYTES;

   logic [3:0][63:0] fmt_ff, fmt_in;
   logic [5:0]  len_ff, len_in, eff_len;
   logic [dfp_pkg::FMT_BYTES-1:0][7:0] fmt_bytes;
   logic [2:0]  reg_idx;
   logic        cfg_wr;

   logic               q_valid, q_pop, res_valid, out_free;
   dfp_pkg::item_type  q_item;
   dfp_pkg::chk_type   chk;
   dfp_pkg::result_type res;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[5:3];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign fmt_bytes  = fmt_ff;
   assign eff_len    = (len_ff > 6'(LEN_CAP)) ? 6'(LEN_CAP) : len_ff;

   always_comb begin
      fmt_in = fmt_ff;
      len_in = len_ff;
      if (cfg_wr) begin
         case (reg_idx)
            dfp_pkg::REG_FMT_A: fmt_in[0] = csr_pwdata;
            dfp_pkg::REG_FMT_B: fmt_in[1] = csr_pwdata;
            dfp_pkg::REG_FMT_C: fmt_in[2] = csr_pwdata;
            dfp_pkg::REG_FMT_D: fmt_in[3] = csr_pwdata;
            dfp_pkg::REG_LEN:   len_in    = csr_pwdata[5:0];
            default: ;
         endcase
      end
      case (reg_idx)
         dfp_pkg::REG_FMT_A: csr_prdata = fmt_ff[0];
         dfp_pkg::REG_FMT_B: csr_prdata = fmt_ff[1];
         dfp_pkg::REG_FMT_C: csr_prdata = fmt_ff[2];
         dfp_pkg::REG_FMT_D: csr_prdata = fmt_ff[3];
         dfp_pkg::REG_LEN:   csr_prdata = {58'd0, len_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= '0;
         len_ff <= '0;
      end else begin
         fmt_ff <= fmt_in;
         len_ff <= len_in;
      end
   end

   dfp_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   dfp_fmt_chk u_chk (
      .clock     (clock),
      .reset     (reset),
      .restart   (cfg_wr),
      .fmt_bytes (fmt_bytes),
      .eff_len   (eff_len),
      .chk       (chk)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   dfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .fmt_bytes (fmt_bytes),
      .eff_len   (eff_len),
      .chk       (chk),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'd0, res.micro, res.second, res.minute, res.hour, res.day,
                         res.month, res.year};
         rsp_user_in  = res.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `DFP_ASSERT_IMP(a_emit_slot_free, clock, reset, res_valid, out_free)
   `DFP_ASSERT_IMP(a_emit_after_scan, clock, reset, res_valid, chk.done)
   `DFP_ASSERT_NEXT(a_write_rescans, clock, reset, cfg_wr, !chk.done)
   `DFP_ASSERT_IMP(a_full_has_head, clock, reset, !req_tready, q_valid)

endmodule

// ===== tb/tb_datetime_format_parser.sv =====
// Self-checking testbench for datetime_format_parser: format registers over APB, date strings
// over the request stream, every result checked against a cycle-free parser model in the bench.
// Depends on dfp_pkg and the block's RTL only.
module tb_datetime_format_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 3000;
   localparam int PHASE_ITEMS = 70;
   localparam int NUM_PHASES = 24;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast, req_tuser;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata, csr_prdata;

   datetime_format_parser dut (.*);

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- parser model ----------------
   logic [7:0]  fmt_mem [dfp_pkg::FMT_BYTES];
   logic [5:0]  fmt_len_reg;
   int unsigned cursor_pos, accum, ndig, name_mask, name_pos, tsub;
   dfp_pkg::phase_type phase;
   dfp_pkg::run_type   run_state;
   dfp_pkg::mer_type   mer_kind, ap_hold;
   logic [7:0]  cur_pat;
   bit          cur_lit, doy_seen, mer_seen, h24_seen, h12_seen;
   int unsigned yr, mon, dom, hr, mn, sec, usec;
   string mon_words [12] = '{"january", "february", "march", "april", "may", "june",
      "july", "august", "september", "october", "november", "december"};

   dfp_pkg::result_type expected_results [$];
   dfp_pkg::result_type last_prediction;
   int          errors = 0;
   bit          calm = 1'b0;

   function automatic bit is_ws(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction
   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction
   function automatic bit is_punct(logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
   endfunction
   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic int unsigned fmt_used();
      return (fmt_len_reg > dfp_pkg::FMT_BYTES) ? dfp_pkg::FMT_BYTES : fmt_len_reg;
   endfunction
   function automatic logic [7:0] fmt_at(int unsigned i);
      return (i >= dfp_pkg::FMT_BYTES) ? 8'h00 : fmt_mem[i];
   endfunction

   function automatic bit pattern_known(logic [7:0] p);
      case (p)
         dfp_pkg::CH_B_LO, dfp_pkg::CH_C_LO, dfp_pkg::CH_D_LO, dfp_pkg::CH_E_LO,
         dfp_pkg::CH_F_LO, dfp_pkg::CH_K_LO, dfp_pkg::CH_H_UP, dfp_pkg::CH_L_LO,
         dfp_pkg::CH_I_UP, dfp_pkg::CH_H_LO, dfp_pkg::CH_I_LO, dfp_pkg::CH_J_LO,
         dfp_pkg::CH_M_UP, dfp_pkg::CH_M_LO, dfp_pkg::CH_S_UP, dfp_pkg::CH_S_LO,
         dfp_pkg::CH_P_LO, dfp_pkg::CH_R_LO, dfp_pkg::CH_T_UP, dfp_pkg::CH_Y_UP,
         dfp_pkg::CH_Y_LO, dfp_pkg::CH_HASH, dfp_pkg::CH_DOT, dfp_pkg::CH_AT,
         dfp_pkg::CH_PCT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit pattern_numeric(logic [7:0] p);
      case (p)
         dfp_pkg::CH_B_LO, dfp_pkg::CH_M_UP, dfp_pkg::CH_P_LO, dfp_pkg::CH_R_LO,
         dfp_pkg::CH_T_UP, dfp_pkg::CH_HASH, dfp_pkg::CH_DOT, dfp_pkg::CH_AT,
         dfp_pkg::CH_PCT: return 1'b0;
         default: return 1'b1;
      endcase
   endfunction

   function automatic int unsigned digit_limit(logic [7:0] p);
      if (p == dfp_pkg::CH_Y_UP) return 4;
      if (p == dfp_pkg::CH_J_LO) return 3;
      if (p == dfp_pkg::CH_F_LO) return 6;
      return 2;
   endfunction

   function automatic bit format_has_bad_pattern();
      int unsigned n, i;
      n = fmt_used();
      i = 0;
      while (i < n) begin
         if (fmt_at(i) == dfp_pkg::CH_PCT) begin
            if (i + 1 >= n) break;
            if (!pattern_known(fmt_at(i + 1))) return 1'b1;
            i += 2;
         end else begin
            i++;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit next_element();
      int unsigned n;
      logic [7:0] c;
      n = fmt_used();
      while (cursor_pos < n) begin
         c = fmt_at(cursor_pos);
         if (is_ws(c)) begin
            cursor_pos++;
            continue;
         end
         if (c == dfp_pkg::CH_PCT) begin
            if (cursor_pos + 1 >= n) begin
               cursor_pos = n;
               return 1'b0;
            end
            cur_pat = fmt_at(cursor_pos + 1);
            cur_lit = 1'b0;
            cursor_pos += 2;
            return 1'b1;
         end
         cur_pat = c;
         cur_lit = 1'b1;
         cursor_pos++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int unsigned pivot_year(int unsigned v);
      if (v <= 69) return v + 2000;
      if (v <= 99) return v + 1900;
      return v;
   endfunction

   function automatic void close_number();
      int unsigned v;
      v = accum;
      phase = dfp_pkg::PH_FETCH;
      if (ndig == 0) begin
         if (cur_pat == dfp_pkg::CH_F_LO) usec = 0;
         else run_state = dfp_pkg::RUN_FAIL;
         return;
      end
      case (cur_pat)
         dfp_pkg::CH_C_LO, dfp_pkg::CH_M_LO:
            if (v > 12) run_state = dfp_pkg::RUN_FAIL; else mon = v;
         dfp_pkg::CH_D_LO, dfp_pkg::CH_E_LO:
            if (v > 31) run_state = dfp_pkg::RUN_FAIL; else dom = v;
         dfp_pkg::CH_F_LO: usec = v * (10 ** (6 - ndig));
         dfp_pkg::CH_K_LO, dfp_pkg::CH_H_UP: begin
            if (v > 23) run_state = dfp_pkg::RUN_FAIL;
            else begin
               hr = v;
               h24_seen = 1'b1;
            end
         end
         dfp_pkg::CH_L_LO, dfp_pkg::CH_I_UP, dfp_pkg::CH_H_LO: begin
            if (v == 0 || v > 12) run_state = dfp_pkg::RUN_FAIL;
            else begin
               hr = v;
               h12_seen = 1'b1;
            end
         end
         dfp_pkg::CH_I_LO: if (v > 59) run_state = dfp_pkg::RUN_FAIL; else mn = v;
         dfp_pkg::CH_J_LO:
            if (v == 0 || v > 366) run_state = dfp_pkg::RUN_FAIL; else doy_seen = 1'b1;
         dfp_pkg::CH_S_UP, dfp_pkg::CH_S_LO:
            if (v > 59) run_state = dfp_pkg::RUN_FAIL; else sec = v;
         dfp_pkg::CH_Y_UP: yr = (ndig <= 2) ? pivot_year(v) : v;
         dfp_pkg::CH_Y_LO: yr = pivot_year(v);
         default: run_state = dfp_pkg::RUN_FAIL;
      endcase
   endfunction

   function automatic void close_time_part();
      int unsigned v;
      bit twelve;
      v = accum;
      twelve = (cur_pat == dfp_pkg::CH_R_LO);
      if (ndig == 0) begin
         run_state = dfp_pkg::RUN_FAIL;
         return;
      end
      if (tsub == 0) begin
         if (twelve ? (v == 0 || v > 12) : (v > 23)) begin
            run_state = dfp_pkg::RUN_FAIL;
            return;
         end
         if (twelve && v == 12) v = 0;
         hr = v;
      end else begin
         if (v > 59) begin
            run_state = dfp_pkg::RUN_FAIL;
            return;
         end
         if (tsub == 1) mn = v; else sec = v;
      end
      if (tsub < 2) phase = dfp_pkg::PH_TSEP;
      else phase = twelve ? dfp_pkg::PH_TAP1 : dfp_pkg::PH_FETCH;
   endfunction

   // returns 1 when the byte is used up
   function automatic bit consume(logic [7:0] c);
      bit in_class;
      int unsigned keep, hit, lim, len;
      case (phase)
         dfp_pkg::PH_FETCH: begin
            if (next_element()) phase = dfp_pkg::PH_START;
            else run_state = dfp_pkg::RUN_DONE;
            return 1'b0;
         end
         dfp_pkg::PH_START: begin
            if (is_ws(c)) return 1'b1;
            if (cur_lit) begin
               if (c == cur_pat) phase = dfp_pkg::PH_FETCH;
               else run_state = dfp_pkg::RUN_FAIL;
               return 1'b1;
            end
            accum = 0;
            ndig = 0;
            if (pattern_numeric(cur_pat)) begin
               phase = dfp_pkg::PH_DIGITS;
               return 1'b0;
            end
            case (cur_pat)
               dfp_pkg::CH_B_LO, dfp_pkg::CH_M_UP: begin
                  name_mask = 12'hFFF;
                  name_pos = 0;
                  phase = dfp_pkg::PH_NAME;
                  return 1'b0;
               end
               dfp_pkg::CH_P_LO: begin
                  if (to_lower(c) == dfp_pkg::CH_A_LO) mer_kind = dfp_pkg::MER_AM;
                  else if (to_lower(c) == dfp_pkg::CH_P_LO) mer_kind = dfp_pkg::MER_PM;
                  else run_state = dfp_pkg::RUN_FAIL;
                  phase = dfp_pkg::PH_P2;
                  return 1'b1;
               end
               dfp_pkg::CH_R_LO, dfp_pkg::CH_T_UP: begin
                  tsub = 0;
                  phase = dfp_pkg::PH_TDIG;
                  return 1'b0;
               end
               dfp_pkg::CH_HASH, dfp_pkg::CH_DOT, dfp_pkg::CH_AT: begin
                  phase = dfp_pkg::PH_SKIP;
                  return 1'b0;
               end
               default: begin
                  run_state = dfp_pkg::RUN_FAIL;
                  return 1'b1;
               end
            endcase
         end
         dfp_pkg::PH_DIGITS: begin
            if (is_digit(c) && ndig < digit_limit(cur_pat)) begin
               accum = accum * 10 + (c - "0");
               ndig++;
               if (ndig == digit_limit(cur_pat)) close_number();
               return 1'b1;
            end
            close_number();
            return 1'b0;
         end
         dfp_pkg::PH_NAME: begin
            keep = 0;
            hit = 12;
            lim = (cur_pat == dfp_pkg::CH_B_LO) ? 3 : 0;
            for (int m = 0; m < 12; m++) begin
               len = (lim != 0) ? lim : mon_words[m].len();
               if (name_mask[m] && name_pos < len && to_lower(c) == mon_words[m][name_pos])
               begin
                  keep |= 1 << m;
                  if (name_pos + 1 == len && hit == 12) hit = m;
               end
            end
            name_mask = keep;
            name_pos++;
            if (hit < 12) begin
               mon = hit + 1;
               phase = dfp_pkg::PH_FETCH;
            end else if (keep == 0) begin
               run_state = dfp_pkg::RUN_FAIL;
            end
            return 1'b1;
         end
         dfp_pkg::PH_P2: begin
            if (to_lower(c) == dfp_pkg::CH_M_LO) begin
               mer_seen = 1'b1;
               phase = dfp_pkg::PH_FETCH;
            end else begin
               run_state = dfp_pkg::RUN_FAIL;
            end
            return 1'b1;
         end
         dfp_pkg::PH_SKIP: begin
            in_class = (cur_pat == dfp_pkg::CH_HASH) ? is_digit(c) :
                       (cur_pat == dfp_pkg::CH_DOT) ? is_punct(c) : is_letter(c);
            if (in_class) return 1'b1;
            phase = dfp_pkg::PH_FETCH;
            return 1'b0;
         end
         dfp_pkg::PH_TDIG: begin
            if (is_digit(c) && ndig < 2) begin
               accum = accum * 10 + (c - "0");
               ndig++;
               if (ndig == 2) close_time_part();
               return 1'b1;
            end
            close_time_part();
            return 1'b0;
         end
         dfp_pkg::PH_TSEP: begin
            if (is_ws(c)) return 1'b1;
            if (c == dfp_pkg::CH_COLON) begin
               tsub++;
               phase = dfp_pkg::PH_TWS;
            end else begin
               run_state = dfp_pkg::RUN_FAIL;
            end
            return 1'b1;
         end
         dfp_pkg::PH_TWS: begin
            if (is_ws(c)) return 1'b1;
            accum = 0;
            ndig = 0;
            phase = dfp_pkg::PH_TDIG;
            return 1'b0;
         end
         dfp_pkg::PH_TAP1: begin
            if (is_ws(c)) return 1'b1;
            if (to_lower(c) == dfp_pkg::CH_A_LO) ap_hold = dfp_pkg::MER_AM;
            else if (to_lower(c) == dfp_pkg::CH_P_LO) ap_hold = dfp_pkg::MER_PM;
            else run_state = dfp_pkg::RUN_FAIL;
            phase = dfp_pkg::PH_TAP2;
            return 1'b1;
         end
         dfp_pkg::PH_TAP2: begin
            if (to_lower(c) == dfp_pkg::CH_M_LO) begin
               if (ap_hold == dfp_pkg::MER_PM) hr += 12;
               phase = dfp_pkg::PH_FETCH;
            end else begin
               run_state = dfp_pkg::RUN_FAIL;
            end
            return 1'b1;
         end
         default: begin
            run_state = dfp_pkg::RUN_FAIL;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic void clear_parse();
      cursor_pos = 0; phase = dfp_pkg::PH_FETCH; accum = 0; ndig = 0;
      yr = 0; mon = 0; dom = 0; hr = 0; mn = 0; sec = 0; usec = 0;
      doy_seen = 0; mer_seen = 0; h24_seen = 0; h12_seen = 0;
      mer_kind = dfp_pkg::MER_NONE; run_state = dfp_pkg::RUN_OK; cur_pat = 8'h00; cur_lit = 0;
      name_mask = 0; name_pos = 0; tsub = 0; ap_hold = dfp_pkg::MER_NONE;
   endfunction

   function automatic dfp_pkg::status_type close_string();
      if (run_state == dfp_pkg::RUN_OK) begin
         case (phase)
            dfp_pkg::PH_DIGITS: close_number();
            dfp_pkg::PH_TDIG: close_time_part();
            dfp_pkg::PH_NAME, dfp_pkg::PH_P2, dfp_pkg::PH_TAP2: run_state = dfp_pkg::RUN_FAIL;
            default: ;
         endcase
      end
      if (format_has_bad_pattern()) return dfp_pkg::ST_BAD_FORMAT;
      if (run_state == dfp_pkg::RUN_FAIL) return dfp_pkg::ST_PARSE_FAIL;
      if (doy_seen) return dfp_pkg::ST_DOY;
      if (mer_seen) begin
         if (h24_seen || hr == 0 || hr > 12) return dfp_pkg::ST_PARSE_FAIL;
         if (hr == 12) hr = (mer_kind == dfp_pkg::MER_AM) ? 0 : 12;
         else if (mer_kind == dfp_pkg::MER_PM) hr += 12;
      end else if (h12_seen && hr == 12) begin
         hr = 0;
      end
      return dfp_pkg::ST_OK;
   endfunction

   function automatic void model_request(logic [7:0] c, logic is_last, logic is_empty);
      dfp_pkg::result_type r;
      if (!is_empty) begin
         for (int guard = 0; guard < 512 && run_state == dfp_pkg::RUN_OK; guard++)
            if (consume(c)) break;
         if (!is_last) return;
      end
      r = '0;
      r.status = close_string();
      if (r.status == dfp_pkg::ST_OK) begin
         r.year = 14'(yr); r.month = 4'(mon); r.day = 5'(dom); r.hour = 5'(hr);
         r.minute = 6'(mn); r.second = 6'(sec); r.micro = 20'(usec);
      end
      expected_results.push_back(r);
      last_prediction = r;
      clear_parse();
   endfunction

   // ---------------- checking ----------------
   task automatic report(string what, longint got, longint want);
      errors++;
      if (errors <= 60) $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   task automatic compare_result(string tag, dfp_pkg::result_type got,
                                 dfp_pkg::result_type want);
      if (got.status !== want.status) report({tag, " status"}, got.status, want.status);
      if (got.year !== want.year) report({tag, " year"}, got.year, want.year);
      if (got.month !== want.month) report({tag, " month"}, got.month, want.month);
      if (got.day !== want.day) report({tag, " day"}, got.day, want.day);
      if (got.hour !== want.hour) report({tag, " hour"}, got.hour, want.hour);
      if (got.minute !== want.minute) report({tag, " minute"}, got.minute, want.minute);
      if (got.second !== want.second) report({tag, " second"}, got.second, want.second);
      if (got.micro !== want.micro) report({tag, " micro"}, got.micro, want.micro);
   endtask

   always @(posedge clock) begin
      dfp_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = dfp_pkg::status_type'(rsp_tuser);
         got.year = rsp_tdata[13:0];
         got.month = rsp_tdata[17:14];
         got.day = rsp_tdata[22:18];
         got.hour = rsp_tdata[27:23];
         got.minute = rsp_tdata[33:28];
         got.second = rsp_tdata[39:34];
         got.micro = rsp_tdata[59:40];
         if (expected_results.size() == 0) report("unexpected result", rsp_tuser, -1);
         else compare_result("result", got, expected_results.pop_front());
      end
   end

   // stall watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[datetime_format_parser] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result-side back-pressure
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
         if (!calm && $urandom_range(7) == 0)
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
      end
   end

   // ---------------- drivers ----------------
   function automatic int pick_gap();
      if (calm || $urandom_range(3) != 0) return 0;
      return ($urandom_range(9) == 0) ? $urandom_range(50, 20) : $urandom_range(3, 1);
   endfunction

   // entered and left at a falling edge
   task automatic send_request(logic [7:0] c, logic is_last, logic is_empty);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = c;
      req_tlast = is_last;
      req_tuser = is_empty;
      do @(posedge clock); while (!req_tready);
      model_request(c, is_last, is_empty);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (idx == dfp_pkg::REG_LEN) begin
         fmt_len_reg = value[5:0];
      end else begin
         for (int b = 0; b < 8; b++) fmt_mem[idx * 8 + b] = value[b * 8 +: 8];
      end
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic load_format(string f, int len, bit all_ones);
      logic [63:0] w [4];
      for (int b = 0; b < dfp_pkg::FMT_BYTES; b++)
         w[b / 8][(b % 8) * 8 +: 8] = all_ones ? 8'hFF : (b < f.len()) ? f[b] : 8'($urandom);
      csr_write(dfp_pkg::REG_FMT_A, w[0]);
      csr_write(dfp_pkg::REG_FMT_B, w[1]);
      csr_write(dfp_pkg::REG_FMT_C, w[2]);
      csr_write(dfp_pkg::REG_FMT_D, w[3]);
      csr_write(dfp_pkg::REG_LEN, all_ones ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(len));
   endtask

   // ---------------- string generation ----------------
   function automatic string mixed_case(string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++)
         if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1)) r[i] = r[i] - 8'd32;
      return r;
   endfunction

   function automatic string meridiem_text();
      return mixed_case($urandom_range(1) ? "am" : "pm");
   endfunction

   function automatic string field_text(logic [7:0] p);
      string s;
      int n;
      case (p)
         dfp_pkg::CH_B_LO: return mixed_case(mon_words[$urandom_range(11)].substr(0, 2));
         dfp_pkg::CH_M_UP: return mixed_case(mon_words[$urandom_range(11)]);
         dfp_pkg::CH_C_LO, dfp_pkg::CH_M_LO: return $sformatf("%02d", $urandom_range(13));
         dfp_pkg::CH_D_LO, dfp_pkg::CH_E_LO: return $sformatf("%02d", $urandom_range(32));
         dfp_pkg::CH_H_UP, dfp_pkg::CH_K_LO: return $sformatf("%02d", $urandom_range(24));
         dfp_pkg::CH_H_LO, dfp_pkg::CH_I_UP, dfp_pkg::CH_L_LO:
            return $sformatf("%02d", $urandom_range(13));
         dfp_pkg::CH_I_LO, dfp_pkg::CH_S_UP, dfp_pkg::CH_S_LO:
            return $sformatf("%02d", $urandom_range(60));
         dfp_pkg::CH_J_LO: return $sformatf("%03d", $urandom_range(367));
         dfp_pkg::CH_Y_LO: return $sformatf("%02d", $urandom_range(99));
         dfp_pkg::CH_P_LO: return meridiem_text();
         dfp_pkg::CH_R_LO: return $sformatf("%02d:%02d:%02d %s", $urandom_range(13, 1),
                     $urandom_range(59), $urandom_range(59), meridiem_text());
         dfp_pkg::CH_T_UP: return $sformatf("%02d: %02d:%02d", $urandom_range(23),
                     $urandom_range(60), $urandom_range(59));
         dfp_pkg::CH_Y_UP, dfp_pkg::CH_F_LO: begin
            n = $urandom_range((p == dfp_pkg::CH_Y_UP) ? 4 : 6, 1);
            s = "";
            for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
            return s;
         end
         dfp_pkg::CH_HASH: return $sformatf("%0d", $urandom_range(999));
         dfp_pkg::CH_DOT: return ($urandom_range(1)) ? "-/" : ",";
         dfp_pkg::CH_AT: return mixed_case("xyz");
         default: return $sformatf("%0d", $urandom_range(9));
      endcase
   endfunction

   function automatic string date_text(string f);
      string s;
      int i;
      s = "";
      i = 0;
      while (i < f.len()) begin
         if ($urandom_range(9) == 0) s = {s, " "};
         if (is_ws(f[i])) begin
            if ($urandom_range(1)) s = {s, "\t"};
            i++;
         end else if (f[i] == dfp_pkg::CH_PCT && i + 1 < f.len()) begin
            s = {s, field_text(f[i + 1])};
            i += 2;
         end else begin
            s = {s, string'(f[i])};
            i++;
         end
      end
      return s;
   endfunction

   task automatic send_string(string s, bit close_empty, ref int count);
      for (int i = 0; i < s.len(); i++) begin
         send_request(s[i], !close_empty && i == s.len() - 1, 1'b0);
         count++;
      end
      if (close_empty || s.len() == 0) begin
         send_request(8'($urandom), 1'($urandom), 1'b1);
         count++;
      end
   endtask

   // ---------------- stimulus ----------------
   typedef struct {
      string      fmt;
      string      txt;
      bit         typed;
      dfp_pkg::status_type st;
      int         y, mo, d, h, mi, s, us;
   } case_row_type;

   case_row_type directed [10] = '{
      '{"%y%m%d", "991231", 1, dfp_pkg::ST_OK, 1999, 12, 31, 0, 0, 0, 0},
      '{"%Z", "1", 1, dfp_pkg::ST_BAD_FORMAT, 0, 0, 0, 0, 0, 0, 0},
      '{"%H:%i", "23:59", 1, dfp_pkg::ST_OK, 0, 0, 0, 23, 59, 0, 0},
      '{"%f", "5", 1, dfp_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 500000},
      '{"%h%p", "12AM", 1, dfp_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0},
      '{"%H%p", "13PM", 1, dfp_pkg::ST_PARSE_FAIL, 0, 0, 0, 0, 0, 0, 0},
      '{"%j", "366", 1, dfp_pkg::ST_DOY, 0, 0, 0, 0, 0, 0, 0},
      '{"%Y", "", 1, dfp_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0},
      '{"%%", "5", 1, dfp_pkg::ST_PARSE_FAIL, 0, 0, 0, 0, 0, 0, 0},
      '{"%b%", "Dec", 1, dfp_pkg::ST_OK, 0, 12, 0, 0, 0, 0, 0}
   };

   string fmt_pool [14] = '{
      "%Y-%m-%d %H:%i:%s", "%d/%m/%y", "%b %e, %Y", "%M %d %Y %h:%i %p", "%r",
      "%T.%f", "%Y%m%d%H%i%S", "%j %Y", "%k:%i %p", "%l %p", "%#%.%@%d",
      "%c/%e/%y %I", "%Y %%", "%d %Q"
   };
   string long_fmt = "%Y-%m-%d %H:%i:%s.%f %p %y %b %%";

   initial begin
      string prev_fmt, f, s;
      dfp_pkg::result_type want;
      int count, pos;
      bit close_empty;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0; req_tuser = 1'b0;
      rsp_tready = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      for (int b = 0; b < dfp_pkg::FMT_BYTES; b++) fmt_mem[b] = 8'h00;
      fmt_len_reg = '0;
      clear_parse();
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed cases
      count = 0;
      prev_fmt = "";
      foreach (directed[k]) begin
         if (directed[k].fmt != prev_fmt) begin
            drain();
            load_format(directed[k].fmt, directed[k].fmt.len(), 1'b0);
            prev_fmt = directed[k].fmt;
         end
         send_string(directed[k].txt, 1'b0, count);
         if (directed[k].typed) begin
            want.status = directed[k].st;
            want.year = 14'(directed[k].y); want.month = 4'(directed[k].mo);
            want.day = 5'(directed[k].d); want.hour = 5'(directed[k].h);
            want.minute = 6'(directed[k].mi); want.second = 6'(directed[k].s);
            want.micro = 20'(directed[k].us);
            compare_result($sformatf("case %0d", k), last_prediction, want);
         end
      end

      // random phases, each under its own format setting
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         calm = (ph % 5 == 3);
         if (ph == 0) begin
            f = "%Y";
            load_format(f, 0, 1'b0);
         end else if (ph == 1) begin
            f = fmt_pool[0];
            load_format(f, 0, 1'b1);
         end else if (ph == 2) begin
            f = long_fmt;
            load_format(f, 63, 1'b0);
         end else if (ph == 3) begin
            f = long_fmt;
            load_format(f, 32, 1'b0);
         end else begin
            f = fmt_pool[$urandom_range(13)];
            load_format(f, f.len(), 1'b0);
         end
         count = 0;
         while (count < PHASE_ITEMS) begin
            s = date_text(f);
            case ($urandom_range(19))
               0: begin
                  s = "";
                  repeat ($urandom_range(6, 1)) s = {s, string'(8'($urandom))};
               end
               1: if (s.len() > 0) begin
                  pos = $urandom_range(s.len() - 1);
                  s[pos] = 8'($urandom_range(255, 1));
               end
               2: if (s.len() > 0) s = s.substr(0, $urandom_range(s.len() - 1));
               default: ;
            endcase
            close_empty = ($urandom_range(7) == 0);
            send_string(s, close_empty, count);
         end
      end

      drain();
      if (errors == 0) begin
         $display("[datetime_format_parser] OK");
      end else begin
         $display("[datetime_format_parser] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dfp_pkg.sv
hw/rtl/dfp_front.sv
hw/rtl/dfp_fmt_chk.sv
hw/rtl/dfp_back.sv
hw/rtl/datetime_format_parser.sv
tb/tb_datetime_format_parser.sv
